// ----- src/fdig_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fdig_pkg
// Types and constants shared by the frame difference with index gain block.
// ----------------------------------------------------------------------------
package fdig_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = 17;
    localparam int OUT_W       = 40;
    localparam int GAIN_W      = 48;
    localparam int GAIN_HALF_W = 24;
    localparam int BASE_W      = 24;
    localparam int RATIO_W     = 32;
    localparam int FRAME_LEN_W = 14;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = GAIN_HALF_W + RATIO_W;
    localparam int MAG_PROD_W  = DIFF_W + GAIN_HALF_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_GAIN    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_RATIO   = 2'd3;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RESET = 14'd5000;
    localparam logic                   SCALE_ENABLE_RESET = 1'b1;
    localparam logic [BASE_W-1:0]      BASE_GAIN_RESET    = 24'd65536;
    localparam logic [RATIO_W-1:0]     GAIN_RATIO_RESET   = 32'd1074112682;

    localparam logic [63:0] START_PROD_RESET =
        64'(BASE_GAIN_RESET) * 64'(GAIN_RATIO_RESET) + 64'd2097152;
    localparam logic [GAIN_W-1:0] START_GAIN_RESET = GAIN_W'(START_PROD_RESET >> 22);
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIFF = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic restart;
    } gain_ctrl_t;

endpackage
`default_nettype wire

// ----- src/frame_difference_with_index_gain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frame_difference_with_index_gain
// Subtracts the same-index sample of the previous frame; with scaling enabled
// it applies an exponential per-index gain, saturating gain and output.
// ----------------------------------------------------------------------------
// Each sample item passes from acceptance to its result through these steps in
// order: reading the previous frame's entry from the line store, forming the
// difference and writing the new sample back, the gain multiplies, and
// rounding, saturating and loading the output register. The next item is
// accepted in the cycle after that result is loaded, so the block takes no new
// item before the last one's result is loaded; the final step waits while the
// output register still holds an untaken result. The line store needs no
// clearing after reset: a fill count makes entries not yet written read as
// zero, so the block takes items at once.
// ----------------------------------------------------------------------------
module frame_difference_with_index_gain #(
    parameter int  FRAME_DEPTH = 8192,
    localparam int AW          = $clog2(FRAME_DEPTH)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [fdig_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fdig_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [fdig_pkg::SAMPLE_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [fdig_pkg::OUT_W-1:0]        difference_value,
    output logic        [AW-1:0]                     sample_index,
    output logic                                     last_in_frame,
    output logic                                     saturated
);
    import fdig_pkg::*;

    localparam int LW = (AW + 1 > FRAME_LEN_W) ? AW + 1 : FRAME_LEN_W;
    localparam int MAG_W = MAG_PROD_W + 9;

    state_t state_reg;
    state_t state_next;

    logic [FRAME_LEN_W-1:0] frame_length_reg;
    logic                   scale_enable_reg;
    logic [BASE_W-1:0]      base_gain_reg;
    logic [RATIO_W-1:0]     gain_ratio_reg;

    logic [AW-1:0]          pos_reg;
    logic [AW-1:0]          pos_next;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   last_reg;
    logic [DIFF_W-1:0]      diff_reg;
    logic [DIFF_W-1:0]      mag_reg;
    logic                   neg_reg;
    logic [MAG_PROD_W-1:0]  p_hi_reg;
    logic [MAG_PROD_W-1:0]  p_lo_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       value_reg;
    logic [AW-1:0]          index_reg;
    logic                   last_out_reg;
    logic                   sat_reg;

    logic                   accept;
    logic                   out_load;
    logic [LW-1:0]          len_cfg;
    logic [LW-1:0]          len_eff;
    logic                   last_now;

    logic [SAMPLE_W-1:0]    prev_data;
    logic                   prev_valid;
    logic [SAMPLE_W-1:0]    prev_sample;
    logic [DIFF_W-1:0]      diff_now;

    logic [MAG_W-1:0]       out_mag;
    logic                   out_over;
    logic [OUT_W-1:0]       scaled_value;
    logic [OUT_W-1:0]       raw_value;
    logic [OUT_W-1:0]       value_now;
    logic                   sat_now;

    logic [GAIN_W-1:0]      running_gain;
    logic                   gain_clipped;
    gain_ctrl_t             gain_ctrl;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_SUM) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RESET;
            scale_enable_reg <= SCALE_ENABLE_RESET;
            base_gain_reg    <= BASE_GAIN_RESET;
            gain_ratio_reg   <= GAIN_RATIO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[FRAME_LEN_W-1:0];
                CFG_SCALE_ENABLE: scale_enable_reg <= cfg_data[0];
                CFG_BASE_GAIN:    base_gain_reg    <= cfg_data[BASE_W-1:0];
                CFG_GAIN_RATIO:   gain_ratio_reg   <= cfg_data[RATIO_W-1:0];
                default:          frame_length_reg <= frame_length_reg;
            endcase
        end
    end

    always_comb
    begin
        len_cfg = LW'(frame_length_reg);
        if (len_cfg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (len_cfg > LW'(FRAME_DEPTH))
        begin
            len_eff = LW'(FRAME_DEPTH);
        end
        else
        begin
            len_eff = len_cfg;
        end
        last_now = ((LW'(pos_reg) + LW'(1)) >= len_eff);
    end

    fdig_line_store #(
        .DEPTH (FRAME_DEPTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (pos_reg),
        .rd_data  (prev_data),
        .rd_valid (prev_valid),
        .wr_en    (state_reg == ST_DIFF),
        .wr_addr  (pos_reg),
        .wr_data  (sample_reg)
    );

    assign gain_ctrl.capture = (state_reg == ST_MUL);
    assign gain_ctrl.update  = out_load;
    assign gain_ctrl.restart = last_reg;

    fdig_gain_unit u_gain_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (gain_ctrl),
        .base_gain    (base_gain_reg),
        .gain_ratio   (gain_ratio_reg),
        .running_gain (running_gain),
        .gain_clipped (gain_clipped)
    );

    always_comb
    begin
        prev_sample = prev_valid ? prev_data : '0;
        diff_now    = {sample_reg[SAMPLE_W-1], sample_reg}
                    - {prev_sample[SAMPLE_W-1], prev_sample};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last_now;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= diff_now;
            neg_reg  <= diff_now[DIFF_W-1];
            mag_reg  <= diff_now[DIFF_W-1] ? (DIFF_W'(0) - diff_now) : diff_now;
        end
        if (state_reg == ST_MUL)
        begin
            p_hi_reg <= mag_reg * running_gain[GAIN_W-1:GAIN_HALF_W];
            p_lo_reg <= mag_reg * running_gain[GAIN_HALF_W-1:0];
        end
    end

    always_comb
    begin
        out_mag = MAG_W'({p_hi_reg, 8'd0})
                + MAG_W'((MAG_W'(p_lo_reg) + MAG_W'(32'd32768)) >> 16);
        if (neg_reg)
        begin
            out_over     = (out_mag > (MAG_W'(1) << (OUT_W - 1)));
            scaled_value = out_over ? (OUT_W'(1) << (OUT_W - 1))
                                    : (OUT_W'(0) - out_mag[OUT_W-1:0]);
        end
        else
        begin
            out_over     = (out_mag > ((MAG_W'(1) << (OUT_W - 1)) - MAG_W'(1)));
            scaled_value = out_over ? ((OUT_W'(1) << (OUT_W - 1)) - OUT_W'(1))
                                    : out_mag[OUT_W-1:0];
        end
        raw_value = {{(OUT_W - DIFF_W - 8){diff_reg[DIFF_W-1]}}, diff_reg, 8'd0};
        value_now = scale_enable_reg ? scaled_value : raw_value;
        sat_now   = scale_enable_reg && (gain_clipped || out_over);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg    <= value_now;
            index_reg    <= pos_reg;
            last_out_reg <= last_reg;
            sat_reg      <= sat_now;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                    pos_next   = last_reg ? '0 : pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign difference_value = value_reg;
    assign sample_index     = index_reg;
    assign last_in_frame    = last_out_reg;
    assign saturated        = sat_reg;

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIFF))
        else $error("Accepted item did not start the difference step.");

    a_work_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |=> (state_reg == ST_MUL) ##1 (state_reg == ST_SUM))
        else $error("Item processing did not advance through the multiply step.");

    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> (pos_reg == '0) && out_valid_reg && last_in_frame)
        else $error("Last item of a frame did not restart the index.");

    a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("Loaded result is not presented.");

endmodule
`default_nettype wire

// ----- src/fdig_line_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fdig_line_store
// Previous-frame sample memory with registered read and a fill count that
// makes entries not yet written read as zero.
// ----------------------------------------------------------------------------
module fdig_line_store #(
    parameter int  DEPTH = 8192,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [fdig_pkg::SAMPLE_W-1:0] rd_data,
    output logic                               rd_valid,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [fdig_pkg::SAMPLE_W-1:0] wr_data
);
    import fdig_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [AW:0]         fill_reg;
    logic [AW:0]         fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Writes always advance from index zero, so the written entries form a prefix.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && ({1'b0, wr_addr} == fill_reg))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd_en)
            begin
                rd_valid_reg <= ({1'b0, rd_addr} < fill_reg);
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule
`default_nettype wire

// ----- src/fdig_gain_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fdig_gain_unit
// Running index gain in unsigned Q24.24, advanced by the ratio once per item
// and restarted from the base gain times the ratio at each frame start, with saturation.
// ----------------------------------------------------------------------------
module fdig_gain_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire fdig_pkg::gain_ctrl_t         ctrl,
    input  wire logic [fdig_pkg::BASE_W-1:0]  base_gain,
    input  wire logic [fdig_pkg::RATIO_W-1:0] gain_ratio,
    output logic      [fdig_pkg::GAIN_W-1:0]  running_gain,
    output logic                              gain_clipped
);
    import fdig_pkg::*;

    logic [PROD_W-1:0] hi_prod_reg;
    logic [PROD_W-1:0] lo_prod_reg;
    logic [PROD_W-1:0] start_prod_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    logic              clipped_reg;
    logic              clipped_next;
    logic [PROD_W:0]   lo_sum;
    logic [GAIN_W+2:0] adv;
    logic              adv_over;
    logic [PROD_W-1:0] start_round;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            hi_prod_reg    <= gain_reg[GAIN_W-1:GAIN_HALF_W] * gain_ratio;
            lo_prod_reg    <= gain_reg[GAIN_HALF_W-1:0] * gain_ratio;
            start_prod_reg <= base_gain * gain_ratio;
        end
    end

    always_comb
    begin
        lo_sum      = (PROD_W+1)'(lo_prod_reg) + (PROD_W+1)'(32'd536870912)
                    + (PROD_W+1)'({hi_prod_reg[5:0], 24'd0});
        adv         = (GAIN_W+3)'(hi_prod_reg[PROD_W-1:6]) + (GAIN_W+3)'(lo_sum[PROD_W:30]);
        adv_over    = (adv > (GAIN_W+3)'(GAIN_MAX));
        start_round = start_prod_reg + PROD_W'(32'd2097152);

        gain_next    = gain_reg;
        clipped_next = clipped_reg;
        if (ctrl.update)
        begin
            if (ctrl.restart)
            begin
                gain_next    = GAIN_W'(start_round >> 22);
                clipped_next = 1'b0;
            end
            else
            begin
                gain_next    = adv_over ? GAIN_MAX : adv[GAIN_W-1:0];
                clipped_next = clipped_reg | adv_over;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= START_GAIN_RESET;
            clipped_reg <= 1'b0;
        end
        else
        begin
            gain_reg    <= gain_next;
            clipped_reg <= clipped_next;
        end
    end

    assign running_gain = gain_reg;
    assign gain_clipped = clipped_reg;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame difference with index gain block.
// A scoreboard predicts each result from the accepted samples and the
// register settings, and the results are compared field by field in order.
// Directed items cover the sample extremes, the frame length corner cases and
// gain and output clipping. Random phases with random settings and random
// handshake gaps follow, then a short run at a frame length equal to the store.
// ----------------------------------------------------------------------------
module tb_top;
    import fdig_pkg::*;

    localparam int DEPTH         = 8192;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int RANDOM_ITEMS  = 420;
    localparam int FINAL_ITEMS   = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_UNITS = 2000000;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    last;
        logic                    sat;
    } frame_result_t;

    class frame_diff_scoreboard;
        logic signed [SAMPLE_W-1:0] line_store [DEPTH];
        logic [GAIN_W-1:0]          gain;
        bit                         gain_clip;
        logic [IDX_W-1:0]           pos;
        logic [FRAME_LEN_W-1:0]     len_reg;
        logic                       en_reg;
        logic [BASE_W-1:0]          base_reg;
        logic [RATIO_W-1:0]         ratio_reg;
        frame_result_t              pending_results[$];
        int                         errors;
        int                         results_seen;
        int                         frames_closed;
        int                         saturated_seen;

        function new();
            foreach (line_store[i])
                line_store[i] = '0;
            len_reg        = FRAME_LENGTH_RESET;
            en_reg         = SCALE_ENABLE_RESET;
            base_reg       = BASE_GAIN_RESET;
            ratio_reg      = GAIN_RATIO_RESET;
            gain           = frame_start_gain();
            gain_clip      = 1'b0;
            pos            = '0;
            errors         = 0;
            results_seen   = 0;
            frames_closed  = 0;
            saturated_seen = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_LENGTH: len_reg   = data[FRAME_LEN_W-1:0];
                CFG_SCALE_ENABLE: en_reg    = data[0];
                CFG_BASE_GAIN:    base_reg  = data[BASE_W-1:0];
                CFG_GAIN_RATIO:   ratio_reg = data[RATIO_W-1:0];
                default:          ;
            endcase
        endfunction

        function logic [GAIN_W-1:0] frame_start_gain();
            logic [63:0] prod;
            prod = 64'(base_reg) * 64'(ratio_reg) + 64'd2097152;
            return GAIN_W'(prod >> 22);
        endfunction

        function void advance_gain();
            logic [80:0] prod;
            prod = 81'(gain) * 81'(ratio_reg) + (81'd1 << 29);
            prod = prod >> 30;
            if (prod > 81'(GAIN_MAX))
            begin
                gain      = GAIN_MAX;
                gain_clip = 1'b1;
            end
            else
            begin
                gain = prod[GAIN_W-1:0];
            end
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned                span;
            logic [IDX_W-1:0]           at;
            logic signed [SAMPLE_W:0]   now_ext;
            logic signed [SAMPLE_W:0]   old_ext;
            logic signed [SAMPLE_W:0]   diff;
            logic [SAMPLE_W:0]          mag_in;
            logic [65:0]                mag;
            logic signed [OUT_W-1:0]    value;
            bit                         last;
            bit                         sat;
            frame_result_t              r;
            span = (len_reg == 0) ? 1 : ((len_reg > DEPTH) ? DEPTH : len_reg);
            at = pos;
            last = (int'(at) + 1 >= span);
            now_ext = s;
            old_ext = line_store[at];
            diff = now_ext - old_ext;
            line_store[at] = s;
            sat = gain_clip;
            if (en_reg)
            begin
                mag_in = (diff < 0) ? -diff : diff;
                mag = (66'(mag_in) * 66'(gain) + 66'd32768) >> 16;
                if (diff < 0)
                begin
                    if (mag > (66'd1 << 39))
                    begin
                        mag = 66'd1 << 39;
                        sat = 1'b1;
                    end
                    value = -mag[OUT_W-1:0];
                end
                else
                begin
                    if (mag > ((66'd1 << 39) - 1))
                    begin
                        mag = (66'd1 << 39) - 1;
                        sat = 1'b1;
                    end
                    value = mag[OUT_W-1:0];
                end
            end
            else
            begin
                value = diff;
                value = value <<< 8;
                sat = 1'b0;
            end
            r.value = value;
            r.index = at;
            r.last  = last;
            r.sat   = sat;
            pending_results.push_back(r);
            if (last)
            begin
                pos       = '0;
                gain      = frame_start_gain();
                gain_clip = 1'b0;
            end
            else
            begin
                pos = at + 1'b1;
                advance_gain();
            end
        endfunction

        function void check_result(logic signed [OUT_W-1:0] value, logic [IDX_W-1:0] index,
                                   logic last, logic sat);
            frame_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: difference_value %0d", value);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value)
            begin
                $error("difference_value: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (index !== want.index)
            begin
                $error("sample_index: expected %0d, got %0d", want.index, index);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_in_frame: expected %0b, got %0b", want.last, last);
                errors++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated: expected %0b, got %0b", want.sat, sat);
                errors++;
            end
            if (want.last)
                frames_closed++;
            if (want.sat)
                saturated_seen++;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_W-1:0]    sample    = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [OUT_W-1:0]       difference_value;
    logic [IDX_W-1:0]              sample_index;
    logic                          last_in_frame;
    logic                          saturated;

    int                            max_gap        = 7;
    bit                            hold_request   = 1'b0;
    int                            settings_count = 0;
    frame_diff_scoreboard          sb             = new();

    frame_difference_with_index_gain #(
        .FRAME_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .difference_value(difference_value),
        .sample_index(sample_index),
        .last_in_frame(last_in_frame),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_UNITS;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    task automatic configure(input logic [FRAME_LEN_W-1:0] len, input logic en,
                             input logic [BASE_W-1:0] base, input logic [RATIO_W-1:0] ratio);
        logic [31:0] noise;
        noise = $urandom;
        put_reg(CFG_FRAME_LENGTH, {noise[31:FRAME_LEN_W], len});
        put_reg(CFG_SCALE_ENABLE, {noise[30:0], en});
        put_reg(CFG_BASE_GAIN, {noise[7:0], base});
        put_reg(CFG_GAIN_RATIO, ratio);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample   <= s;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.take_sample(s);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return sb.line_store[sb.pos];
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin : result_side
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, max_gap);
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            sb.check_result(difference_value, sample_index, last_in_frame, saturated);
        end
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] extremes [4];
        logic [FRAME_LEN_W-1:0]     len;
        logic [BASE_W-1:0]          base;
        logic [RATIO_W-1:0]         ratio;
        int                         random_items;
        int                         phase;
        int                         n;
        extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
        random_items = 0;
        phase = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First frame after reset, compared against the cleared store.
        foreach (extremes[i])
            send_sample(extremes[i]);
        stop_input();
        drain();

        // Zero frame length with the largest gains; a zero length acts as a length of
        // one, so every item closes the frame.
        configure(14'd0, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        stop_input();
        drain();

        // Gain grows fourfold per sample until it clips within the frame.
        configure(14'd10, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
        repeat (10) send_sample(16'sh0000);
        stop_input();
        drain();

        // Raw difference with a frame length above the store size.
        configure(14'h3FFF, 1'b0, 24'h000000, 32'h00000000);
        foreach (extremes[i])
            send_sample(extremes[i]);
        stop_input();
        drain();

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       len = 14'd0;
                1:       len = 14'd1;
                2:       len = FRAME_LEN_W'($urandom_range(8193, 16383));
                default: len = FRAME_LEN_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       base = 24'h000000;
                1:       base = 24'hFFFFFF;
                2:       base = BASE_W'($urandom);
                default: base = BASE_W'($urandom_range(32768, 131072));
            endcase
            case ($urandom_range(0, 5))
                0:       ratio = 32'h00000000;
                1:       ratio = 32'hFFFFFFFF;
                2:       ratio = $urandom;
                default: ratio = $urandom_range(32'h3F000000, 32'h41000000);
            endcase
            configure(len, 1'($urandom_range(0, 1)), base, ratio);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
            if (phase == 1)
                hold_request = 1'b1;
            n = $urandom_range(20, 60);
            repeat (n) send_sample(random_sample());
            random_items += n;
            stop_input();
            drain();
            phase++;
        end

        // A frame length equal to the store size with short handshake gaps.
        configure(14'd8192, 1'b1, BASE_GAIN_RESET, GAIN_RATIO_RESET);
        max_gap = 1;
        repeat (FINAL_ITEMS) send_sample(random_sample());
        stop_input();
        drain();
        repeat (16) @(posedge clk);

        $display("Checked %0d results over %0d register settings; %0d frames closed.",
                 sb.results_seen, settings_count, sb.frames_closed);
        $display("%0d results were saturated; the last settings used a %0d-sample frame.",
                 sb.saturated_seen, DEPTH);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
src/fdig_pkg.sv
src/fdig_line_store.sv
src/fdig_gain_unit.sv
src/frame_difference_with_index_gain.sv
test/tb_top.sv
